@@ hw/rtl/two_level_page_walker_core_macros.svh @@
// Assertion macros shared by the page walker RTL.
// No dependencies; included by the files that carry assertions.
`ifndef TWO_LEVEL_PAGE_WALKER_CORE_MACROS_SVH
`define TWO_LEVEL_PAGE_WALKER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, disabled while reset is high.
`define PTW_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("page walker assertion failed");
// Clocked property that is also checked during reset.
`define PTW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("page walker assertion failed");
`else
`define PTW_ASSERT(lbl, clk, rst, prop)
`define PTW_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ hw/rtl/ptw_pkg.sv @@
// Shared types, codes and address masks for the two-level page walker.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps
package ptw_pkg;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSLATE_USER       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSLATE_SUPERVISOR = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DUAL_SPACE           = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TABLE_BASE_ZERO      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TABLE_BASE_ONE       = 3'd4;

  // Input item function codes.
  localparam logic FUNC_REQUEST  = 1'b0;
  localparam logic FUNC_RESPONSE = 1'b1;

  // Result kinds and status codes.
  localparam logic KIND_READ      = 1'b0;
  localparam logic KIND_DONE      = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // Virtual address and entry fields.
  localparam logic [31:0] IDX1_MASK  = 32'hffc0_0000;
  localparam logic [31:0] IDX2_MASK  = 32'h003f_f000;
  localparam logic [31:0] OFFS_MASK  = 32'h0000_0fff;
  localparam logic [31:0] FRAME_MASK = 32'hffff_f000;
  localparam logic [31:0] ENTRY_OK   = 32'h0000_0001;

  typedef struct packed {
    logic        translate_user;
    logic        translate_supervisor;
    logic        dual_space;
    logic [31:0] table_base_zero;
    logic [31:0] table_base_one;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [31:0] virtual_address;
    logic        use_given_base;
    logic [31:0] given_base;
    logic        user_mode;
    logic [31:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic        status;
  } result_t;

endpackage

@@ hw/rtl/ptw_cfg_regs.sv @@
// Mode and table base registers of the page walker.
// Depends on ptw_pkg.
`timescale 1ns / 1ps
module ptw_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ptw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ptw_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ptw_pkg::cfg_t                    cfg
);
  import ptw_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRANSLATE_USER:       regs.translate_user       <= cfg_data[0];
        REG_TRANSLATE_SUPERVISOR: regs.translate_supervisor <= cfg_data[0];
        REG_DUAL_SPACE:           regs.dual_space           <= cfg_data[0];
        REG_TABLE_BASE_ZERO:      regs.table_base_zero      <= cfg_data;
        REG_TABLE_BASE_ONE:       regs.table_base_one       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

@@ hw/rtl/ptw_walk.sv @@
// Walk state and single-pass translation logic of the page walker.
// Depends on ptw_pkg and the macro header.
`timescale 1ns / 1ps
`include "two_level_page_walker_core_macros.svh"
module ptw_walk (
  input  logic              clk,
  input  logic              rst,
  input  ptw_pkg::cfg_t     cfg,
  input  ptw_pkg::in_item_t item,
  input  logic              step,
  output logic              has_result,
  output ptw_pkg::result_t  result
);
  import ptw_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic [31:0] held_address;
  logic [31:0] held_address_next;
  logic        busy;
  logic [31:0] mode_base;
  logic [31:0] base;

  assign busy = (phase == PH_FIRST) || (phase == PH_SECOND);

  always_comb begin
    mode_base = '0;
    if (item.user_mode && cfg.translate_user) begin
      mode_base = cfg.dual_space ? cfg.table_base_one : cfg.table_base_zero;
    end else if (!item.user_mode && cfg.translate_supervisor) begin
      mode_base = cfg.table_base_zero;
    end
  end

  assign base = item.use_given_base ? item.given_base : mode_base;

  always_comb begin
    phase_next        = phase;
    held_address_next = held_address;
    has_result        = 1'b0;
    result.kind       = KIND_READ;
    result.address    = '0;
    result.status     = STATUS_OK;
    if (item.func == FUNC_REQUEST) begin
      if (!busy) begin
        has_result = 1'b1;
        if (base == '0) begin
          // No translation: the address comes back as it is.
          phase_next     = PH_IDLE;
          result.kind    = KIND_DONE;
          result.address = item.virtual_address;
        end else begin
          phase_next        = PH_FIRST;
          held_address_next = item.virtual_address;
          result.address    = base | ((item.virtual_address & IDX1_MASK) >> 20);
        end
      end
    end else if (busy) begin
      has_result = 1'b1;
      if ((item.read_data & ENTRY_OK) == '0) begin
        phase_next     = PH_IDLE;
        result.kind    = KIND_DONE;
        result.status  = STATUS_INVALID;
      end else if (phase == PH_FIRST) begin
        phase_next     = PH_SECOND;
        result.address = (item.read_data & FRAME_MASK) |
                         ((held_address & IDX2_MASK) >> 10);
      end else begin
        phase_next     = PH_IDLE;
        result.kind    = KIND_DONE;
        result.address = (item.read_data & FRAME_MASK) | (held_address & OFFS_MASK);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      held_address <= '0;
    end else if (step) begin
      phase        <= phase_next;
      held_address <= held_address_next;
    end
  end

  `PTW_ASSERT(a_read_starts_walk, clk, rst,
    step && has_result && (result.kind == KIND_READ) |=> busy)
  `PTW_ASSERT(a_done_ends_walk, clk, rst,
    step && has_result && (result.kind == KIND_DONE) |=> (phase == PH_IDLE))
  `PTW_ASSERT(a_hold_without_step, clk, rst,
    !step |=> $stable(phase) && $stable(held_address))

endmodule

@@ hw/rtl/two_level_page_walker_core.sv @@
// A transfer accepted on the slave side goes through the input register, the single-pass
// logic and the result register to the master side. Throughput: one item per cycle,
// set by that logic, while the result register is empty or taken; else the slave stalls.
// Requests while a walk is busy and responses while idle give no result and never stall.
// Reset (rst, synchronous, active high) empties both registers, sets the walk to idle
// and clears all mode and table base registers.
`timescale 1ns / 1ps
module two_level_page_walker_core (
  input  logic                             clk,
  input  logic                             rst,
  // Slave side: tdata holds, from the lowest bit up, virtual_address[31:0],
  // use_given_base, given_base[31:0], user_mode, read_data[31:0], six zero bits.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ptw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Slave side tuser: func (0 request, 1 memory read response).
  input  logic [0:0]                       s_axis_tuser,
  // Master side: tdata holds, from the lowest bit up, address[31:0], status,
  // seven zero bits.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ptw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // Master side tuser: kind (0 memory read request, 1 translation finished).
  output logic [0:0]                       m_axis_tuser,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [ptw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ptw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ptw_pkg::*;

  cfg_t     cfg;
  in_item_t in_q;
  logic     in_valid;
  logic     advance;
  logic     has_result;
  result_t  result;
  result_t  out_q;
  logic     out_valid;

  ptw_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held item moves on when the result register can take its result,
  // or at once when it produces no result at all.
  assign advance       = in_valid && (!out_valid || m_axis_tready || !has_result);
  assign s_axis_tready = !in_valid || advance;

  // Input register: captures one transfer, unpacked into its fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.func            <= s_axis_tuser[0];
      in_q.virtual_address <= s_axis_tdata[31:0];
      in_q.use_given_base  <= s_axis_tdata[32];
      in_q.given_base      <= s_axis_tdata[64:33];
      in_q.user_mode       <= s_axis_tdata[65];
      in_q.read_data       <= s_axis_tdata[97:66];
    end
  end

  // The walk state advances only with the item that the input register hands on.
  ptw_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (in_q),
    .step       (advance),
    .has_result (has_result),
    .result     (result)
  );

  // Result register: holds one result until the master side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && has_result) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {7'b0, out_q.status, out_q.address};

endmodule

@@ verif/two_level_page_walker_core_tb.sv @@
// Self-checking testbench for two_level_page_walker_core: random and directed walks,
// predicted in the bench and compared transfer by transfer on the master side.
// Depends on ptw_pkg for the port widths, register indexes, codes and masks.
`timescale 1ns / 1ps
module two_level_page_walker_core_tb;
  import ptw_pkg::*;

  localparam int LIMIT_CYCLES = 500000;  // far above the slowest correct run
  localparam int SETTLE       = 8;       // two register stages plus margin
  localparam int LONG_HOLD    = 400;     // receiver hold-off that backs up the block
  localparam int PHASES       = 10;
  localparam int WALKS        = 66;      // random walk sequences per phase

  // Phase of the walk as the bench predicts it.
  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_FIRST,
    WALK_SECOND
  } walk_phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  two_level_page_walker_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the mode registers and of the walk state.
  cfg_t        mode_regs = '0;
  walk_phase_e walk_at   = WALK_IDLE;
  logic [31:0] held_va   = '0;

  in_item_t pending_items[$];     // items still to be offered on the slave side
  result_t  due_walk_results[$];  // read requests and translations still to arrive
  in_item_t offered;              // item currently on the slave side
  logic     offer_live = 1'b0;    // offered item not yet taken by the block

  int   gap_left = 0;
  int   stall_left = 0;
  logic long_hold_req = 1'b0;
  logic calm = 1'b0;              // no idling on either side in the last phase
  int   mismatch_count = 0;
  int   cycle_count = 0;
  result_t seen, want;

  function automatic in_item_t walk_item(input logic func, input logic [31:0] va,
                                         input logic use_given, input logic [31:0] given,
                                         input logic user, input logic [31:0] entry);
    in_item_t it;
    it.func            = func;
    it.virtual_address = va;
    it.use_given_base  = use_given;
    it.given_base      = given;
    it.user_mode       = user;
    it.read_data       = entry;
    return it;
  endfunction

  // A new translation request; about one in four carries its own table base,
  // and some of those a zero base, which means no translation.
  function automatic in_item_t rand_request();
    logic [31:0] given;
    given = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom;
    return walk_item(FUNC_REQUEST, $urandom, $urandom_range(0, 3) == 0, given,
                     1'($urandom_range(0, 1)), $urandom);
  endfunction

  // A memory response; bit 0 of the entry decides whether it is valid. The
  // request fields carry random bits that the block must ignore.
  function automatic in_item_t rand_response(input logic ok);
    logic [31:0] entry;
    entry    = $urandom;
    entry[0] = ok;
    return walk_item(FUNC_RESPONSE, $urandom, 1'($urandom_range(0, 1)), $urandom,
                     1'($urandom_range(0, 1)), entry);
  endfunction

  // Works out what one accepted item causes and queues the expected transfer.
  task automatic predict_walk(input in_item_t it);
    logic [31:0] base;
    result_t     r;
    r.status = STATUS_OK;
    if (it.func == FUNC_REQUEST) begin
      // A request during a walk is dropped without any effect.
      if (walk_at != WALK_IDLE) return;
      if (it.use_given_base) begin
        base = it.given_base;
      end else if (it.user_mode && mode_regs.translate_user) begin
        base = mode_regs.dual_space ? mode_regs.table_base_one : mode_regs.table_base_zero;
      end else if (!it.user_mode && mode_regs.translate_supervisor) begin
        base = mode_regs.table_base_zero;
      end else begin
        base = 32'h0;
      end
      if (base == 32'h0) begin
        // No table: the address passes through as the physical address.
        r.kind    = KIND_DONE;
        r.address = it.virtual_address;
      end else begin
        held_va   = it.virtual_address;
        walk_at   = WALK_FIRST;
        r.kind    = KIND_READ;
        r.address = base | ((it.virtual_address & IDX1_MASK) >> 20);
      end
    end else begin
      // A response with no walk in progress is dropped.
      if (walk_at == WALK_IDLE) return;
      if ((it.read_data & ENTRY_OK) == 32'h0) begin
        walk_at   = WALK_IDLE;
        r.kind    = KIND_DONE;
        r.address = 32'h0;
        r.status  = STATUS_INVALID;
      end else if (walk_at == WALK_FIRST) begin
        walk_at   = WALK_SECOND;
        r.kind    = KIND_READ;
        r.address = (it.read_data & FRAME_MASK) | ((held_va & IDX2_MASK) >> 10);
      end else begin
        walk_at   = WALK_IDLE;
        r.kind    = KIND_DONE;
        r.address = (it.read_data & FRAME_MASK) | (held_va & OFFS_MASK);
      end
    end
    due_walk_results.push_back(r);
  endtask

  task automatic note_mismatch(input string what, input result_t exp_r, input result_t got_r);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected kind %0d address %h status %0d, %s %0d address %h status %0d",
               $realtime, what, exp_r.kind, exp_r.address, exp_r.status,
               "got kind", got_r.kind, got_r.address, got_r.status);
  endtask

  // One register write; the bench copy follows at the same moment.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      REG_TRANSLATE_USER:       mode_regs.translate_user       = value[0];
      REG_TRANSLATE_SUPERVISOR: mode_regs.translate_supervisor = value[0];
      REG_DUAL_SPACE:           mode_regs.dual_space           = value[0];
      REG_TABLE_BASE_ZERO:      mode_regs.table_base_zero      = value;
      REG_TABLE_BASE_ONE:       mode_regs.table_base_one       = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Waits until every item has been taken and every expected transfer has
  // arrived, then lets the pipeline drain: a dropped item may still be inside.
  task automatic drain();
    while (pending_items.size() != 0 || offer_live || due_walk_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Sender, acceptance side: a transfer happens at the rising edge where
  // tvalid and tready are both high, and that is when the item is predicted.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predict_walk(offered);
      offer_live = 1'b0;
    end
  end

  // Sender, drive side: an offered item stays on the bus until it is taken.
  // After an item a random gap may follow.
  always @(negedge clk) begin
    if (rst || offer_live) begin
      // Keep the current offer (or stay quiet in reset).
    end else if (gap_left > 0) begin
      s_axis_tvalid <= 1'b0;
      gap_left--;
    end else if (pending_items.size() != 0) begin
      offered = pending_items.pop_front();
      s_axis_tdata  <= {6'b0, offered.read_data, offered.user_mode, offered.given_base,
                        offered.use_given_base, offered.virtual_address};
      s_axis_tuser  <= offered.func;
      s_axis_tvalid <= 1'b1;
      offer_live = 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 19);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // block fills up and has to lower s_axis_tready.
  always @(negedge clk) begin
    if (long_hold_req) begin
      stall_left    = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (!calm && !rst && $urandom_range(0, 15) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(1, 19) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: each transfer on the master side is checked against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.kind    = m_axis_tuser[0];
      seen.address = m_axis_tdata[31:0];
      seen.status  = m_axis_tdata[32];
      if (due_walk_results.size() == 0) begin
        want = '0;
        note_mismatch("unexpected transfer", want, seen);
      end else begin
        want = due_walk_results.pop_front();
        if (seen.kind !== want.kind || seen.address !== want.address ||
            seen.status !== want.status)
          note_mismatch("wrong transfer", want, seen);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int          ph;
    int          k;
    int          pick;
    logic        tu;
    logic        ts;
    logic        ds;
    logic [31:0] b0;
    logic [31:0] b1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with the mode registers still at their reset values, so
    // only an explicit nonzero base starts a walk.
    pending_items.push_back(walk_item(FUNC_REQUEST, 32'h0, 1'b0, 32'h0, 1'b0, 32'h0));
    pending_items.push_back(walk_item(FUNC_REQUEST, '1, 1'b0, 32'h0, 1'b1, '1));
    // Response while idle.
    pending_items.push_back(walk_item(FUNC_RESPONSE, '1, 1'b1, '1, 1'b1, '1));
    // All-ones walk, with a request arriving while busy.
    pending_items.push_back(walk_item(FUNC_REQUEST, '1, 1'b1, '1, 1'b1, '1));
    pending_items.push_back(walk_item(FUNC_REQUEST, 32'h0, 1'b1, 32'h4000, 1'b0, 32'h0));
    pending_items.push_back(walk_item(FUNC_RESPONSE, 32'h0, 1'b0, 32'h0, 1'b0, '1));
    pending_items.push_back(walk_item(FUNC_RESPONSE, 32'h0, 1'b0, 32'h0, 1'b0, '1));
    // Invalid first-level entry.
    pending_items.push_back(walk_item(FUNC_REQUEST, 32'h1234_5678, 1'b1, 32'h1000, 1'b0,
                                      32'h0));
    pending_items.push_back(walk_item(FUNC_RESPONSE, 32'h0, 1'b0, 32'h0, 1'b0, 32'hffff_fffe));
    // Invalid second-level entry.
    pending_items.push_back(walk_item(FUNC_REQUEST, 32'h0, 1'b1, 32'h2000, 1'b1, 32'h0));
    pending_items.push_back(walk_item(FUNC_RESPONSE, 32'h0, 1'b0, 32'h0, 1'b0, 32'h1));
    pending_items.push_back(walk_item(FUNC_RESPONSE, 32'h0, 1'b0, 32'h0, 1'b0, 32'h0));
    // Walk ending in a plain translation with mixed bits.
    pending_items.push_back(walk_item(FUNC_REQUEST, 32'ha5a5_5a5a, 1'b1, 32'h0000_0001,
                                      1'b0, 32'h0));
    pending_items.push_back(walk_item(FUNC_RESPONSE, 32'h0, 1'b0, 32'h0, 1'b0, 32'h0000_1001));
    pending_items.push_back(walk_item(FUNC_RESPONSE, 32'h0, 1'b0, 32'h0, 1'b0, 32'h8765_4321));
    // An explicit zero base means no translation.
    pending_items.push_back(walk_item(FUNC_REQUEST, 32'hdead_beef, 1'b1, 32'h0, 1'b1, 32'h0));
    drain();

    // Random phases, each under its own mode setting. The first four are the
    // extremes; the last one runs without idling on either side.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin tu = 1'b1; ts = 1'b1; ds = 1'b0; b0 = '1;          b1 = 32'h0; end
        1: begin tu = 1'b1; ts = 1'b0; ds = 1'b1; b0 = 32'h0;       b1 = '1;    end
        2: begin tu = 1'b0; ts = 1'b1; ds = 1'b1; b0 = 32'h1000;    b1 = $urandom; end
        3: begin tu = 1'b0; ts = 1'b0; ds = 1'b0; b0 = 32'h0;       b1 = 32'h0; end
        default: begin
          tu = 1'($urandom_range(0, 1));
          ts = 1'($urandom_range(0, 1));
          ds = 1'($urandom_range(0, 1));
          b0 = ($urandom_range(0, 5) == 0) ? 32'h0 : $urandom;
          b1 = ($urandom_range(0, 5) == 0) ? 32'h0 : $urandom;
        end
      endcase
      write_reg(REG_TRANSLATE_USER, {31'b0, tu});
      write_reg(REG_TRANSLATE_SUPERVISOR, {31'b0, ts});
      write_reg(REG_DUAL_SPACE, {31'b0, ds});
      write_reg(REG_TABLE_BASE_ZERO, b0);
      write_reg(REG_TABLE_BASE_ONE, b1);

      if (ph == PHASES - 1) calm = 1'b1;
      // Long receiver hold-off while full walks keep coming in.
      if (ph == 2) long_hold_req = 1'b1;

      for (k = 0; k < WALKS; k++) begin
        pick = $urandom_range(0, 9);
        if (pick == 8) begin
          // Stray response, most likely with no walk in progress.
          pending_items.push_back(rand_response(1'($urandom_range(0, 1))));
        end else begin
          pending_items.push_back(rand_request());
          // A second request that lands on a busy walk.
          if (pick == 9) pending_items.push_back(rand_request());
          pending_items.push_back(rand_response($urandom_range(0, 9) != 0));
          pending_items.push_back(rand_response($urandom_range(0, 9) != 0));
        end
      end
      drain();
    end

    if (mismatch_count == 0 && due_walk_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
